// ----- rtl/ple_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the positional list engine.
// No dependencies; imported by every module of the block.
package ple_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W = 4;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int OUT_W  = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [KIND_W-1:0] K_INS_FIRST  = 4'd0;
    localparam logic [KIND_W-1:0] K_INS_LAST   = 4'd1;
    localparam logic [KIND_W-1:0] K_INS_AT     = 4'd2;
    localparam logic [KIND_W-1:0] K_DEL_FIRST  = 4'd3;
    localparam logic [KIND_W-1:0] K_DEL_LAST   = 4'd4;
    localparam logic [KIND_W-1:0] K_DEL_AT     = 4'd5;
    localparam logic [KIND_W-1:0] K_FIND_FIRST = 4'd6;
    localparam logic [KIND_W-1:0] K_FIND_LAST  = 4'd7;
    localparam logic [KIND_W-1:0] K_COUNT_KEY  = 4'd8;
    localparam logic [KIND_W-1:0] K_COUNT      = 4'd9;
    localparam logic [KIND_W-1:0] K_REVERSE    = 4'd10;
    localparam logic [KIND_W-1:0] K_CLEAR      = 4'd11;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP, OP_INS, OP_DEL, OP_FIND_FIRST, OP_FIND_LAST,
        OP_COUNT_KEY, OP_COUNT, OP_REV, OP_CLEAR
    } t_opc;

    typedef enum logic [1:0] {W_FIRST, W_LAST, W_AT} t_where;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] removed_value;
        logic [OUT_W-1:0]        found_position;
        logic [OUT_W-1:0]        tally;
    } t_res;

    typedef struct packed {
        t_opc                    opc;
        t_where                  where;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_op;

endpackage

// ----- rtl/ple_front.sv -----
`timescale 1ns / 1ps
// Front stage: accepts requests and classifies them into operations.
// Depends on ple_pkg.
module ple_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  ple_pkg::t_req i_req,
    output logic          o_req_stall,
    output logic          o_op_valid,
    output ple_pkg::t_op  o_op,
    input  logic          i_op_stall
);
    import ple_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic w_take;

    assign o_req_stall = r_valid && i_op_stall;
    assign w_take      = i_req_valid && !o_req_stall;
    assign o_op_valid  = r_valid;
    assign o_op        = r_op;

    always_comb begin
        n_op.position = i_req.position;
        n_op.value    = i_req.value;
        n_op.where    = W_AT;
        unique case (i_req.kind)
            K_INS_FIRST: begin n_op.opc = OP_INS; n_op.where = W_FIRST; end
            K_INS_LAST: begin n_op.opc = OP_INS; n_op.where = W_LAST; end
            K_INS_AT: begin n_op.opc = OP_INS; end
            K_DEL_FIRST: begin n_op.opc = OP_DEL; n_op.where = W_FIRST; end
            K_DEL_LAST: begin n_op.opc = OP_DEL; n_op.where = W_LAST; end
            K_DEL_AT: begin n_op.opc = OP_DEL; end
            K_FIND_FIRST: n_op.opc = OP_FIND_FIRST;
            K_FIND_LAST: n_op.opc = OP_FIND_LAST;
            K_COUNT_KEY: n_op.opc = OP_COUNT_KEY;
            K_COUNT: n_op.opc = OP_COUNT;
            K_REVERSE: n_op.opc = OP_REV;
            K_CLEAR: n_op.opc = OP_CLEAR;
            default: n_op.opc = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op <= n_op;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (!i_op_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ----- rtl/ple_queue.sv -----
`timescale 1ns / 1ps
// Short operation queue between front and back stages.
// Depends on ple_pkg.
module ple_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  ple_pkg::t_op i_op,
    output logic         o_stall,
    output logic         o_valid,
    output ple_pkg::t_op o_op,
    input  logic         i_stall
);
    import ple_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_stall = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_op;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/ple_back.sv -----
`timescale 1ns / 1ps
// Back stage: list memory, walk sequencer and result register.
// Depends on ple_pkg.
module ple_back #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  ple_pkg::t_op  i_op,
    output logic          o_op_stall,
    output logic          o_res_valid,
    output ple_pkg::t_res o_res,
    input  logic          i_res_stall
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_FIN, S_RA, S_RB, S_RC, S_RD
    } t_state;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd;

    t_state                r_state,   n_state;
    logic [CW-1:0]         r_count,   n_count;
    logic [AW-1:0]         r_src,     n_src;
    logic [AW-1:0]         r_end,     n_end;
    logic [AW-1:0]         r_psrc,    n_psrc;
    logic [AW-1:0]         r_at,      n_at;
    logic [AW-1:0]         r_lo,      n_lo;
    logic [AW-1:0]         r_hi,      n_hi;
    logic                  r_up,      n_up;
    logic                  r_going,   n_going;
    logic                  r_pend,    n_pend;
    logic [DATA_WIDTH-1:0] r_tmp,     n_tmp;
    logic [DATA_WIDTH-1:0] r_removed, n_removed;
    logic [CW-1:0]         r_found,   n_found;
    logic [CW-1:0]         r_tally,   n_tally;
    t_op                   r_op,      n_op;
    logic                  r_ovalid,  n_ovalid;
    t_res                  r_res,     n_res;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic                  w_take;
    logic [DATA_WIDTH-1:0] w_key;
    logic [PW-1:0]         w_pos;
    logic [PW-1:0]         w_cnt;
    logic [AW-1:0]         w_at;

    assign w_take      = i_op_valid && (r_state == S_IDLE) && (!r_ovalid || !i_res_stall);
    assign o_op_stall  = !((r_state == S_IDLE) && (!r_ovalid || !i_res_stall));
    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;
    assign w_key       = DATA_WIDTH'(r_op.value);
    assign w_pos       = PW'(i_op.position);
    assign w_cnt       = PW'(r_count);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_src     = r_src;
        n_end     = r_end;
        n_psrc    = r_psrc;
        n_at      = r_at;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_up      = r_up;
        n_going   = r_going;
        n_pend    = r_pend;
        n_tmp     = r_tmp;
        n_removed = r_removed;
        n_found   = r_found;
        n_tally   = r_tally;
        n_op      = r_op;
        n_ovalid  = r_ovalid;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_psrc;
        w_wdata   = r_rd;
        w_raddr   = r_src;
        w_at      = '0;

        if (r_ovalid && !i_res_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_op      = i_op;
                    n_found   = '0;
                    n_tally   = '0;
                    n_removed = '0;
                    n_pend    = 1'b0;
                    n_res     = '0;
                    unique case (i_op.opc)
                        OP_INS: begin
                            if (i_op.where == W_FIRST) begin
                                w_at = '0;
                            end else if (i_op.where == W_LAST) begin
                                w_at = AW'(r_count);
                            end else begin
                                w_at = AW'(w_pos - PW'(1));
                            end
                            if (i_op.where == W_AT && (w_pos == '0 || w_pos > w_cnt + PW'(1))) begin
                                n_res.status = ST_BADPOS;
                                n_ovalid     = 1'b1;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                                n_ovalid     = 1'b1;
                            end else begin
                                n_at = w_at;
                                if (CW'(w_at) == r_count) begin
                                    n_state = S_FIN;
                                end else begin
                                    n_src   = AW'(r_count - CW'(1));
                                    n_end   = w_at;
                                    n_up    = 1'b0;
                                    n_going = 1'b1;
                                    n_state = S_RUN;
                                end
                            end
                        end
                        OP_DEL: begin
                            if (i_op.where == W_FIRST) begin
                                w_at = '0;
                            end else if (i_op.where == W_LAST) begin
                                w_at = AW'(r_count - CW'(1));
                            end else begin
                                w_at = AW'(w_pos - PW'(1));
                            end
                            if (i_op.where != W_AT && r_count == '0) begin
                                n_res.status = ST_EMPTY;
                                n_ovalid     = 1'b1;
                            end else if (i_op.where == W_AT && (w_pos == '0 || w_pos > w_cnt)) begin
                                n_res.status = ST_BADPOS;
                                n_ovalid     = 1'b1;
                            end else begin
                                n_at    = w_at;
                                n_src   = w_at;
                                n_end   = AW'(r_count - CW'(1));
                                n_up    = 1'b1;
                                n_going = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        OP_FIND_FIRST, OP_FIND_LAST, OP_COUNT_KEY: begin
                            if (r_count == '0) begin
                                n_ovalid = 1'b1;
                            end else begin
                                n_src   = '0;
                                n_end   = AW'(r_count - CW'(1));
                                n_up    = 1'b1;
                                n_going = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        OP_COUNT: begin
                            n_res.tally = OUT_W'(r_count);
                            n_ovalid    = 1'b1;
                        end
                        OP_REV: begin
                            if (r_count > CW'(1)) begin
                                n_lo    = '0;
                                n_hi    = AW'(r_count - CW'(1));
                                n_state = S_RA;
                            end else begin
                                n_ovalid = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_ovalid = 1'b1;
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            S_RUN: begin
                if (r_pend) begin
                    case (r_op.opc)
                        OP_INS: begin
                            w_we    = 1'b1;
                            w_waddr = r_psrc + AW'(1);
                        end
                        OP_DEL: begin
                            if (r_psrc == r_at) begin
                                n_removed = r_rd;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_psrc - AW'(1);
                            end
                        end
                        OP_FIND_FIRST: begin
                            if (r_rd == w_key && r_found == '0) begin
                                n_found = CW'(r_psrc) + CW'(1);
                            end
                        end
                        OP_FIND_LAST: begin
                            if (r_rd == w_key) begin
                                n_found = CW'(r_psrc) + CW'(1);
                            end
                        end
                        OP_COUNT_KEY: begin
                            if (r_rd == w_key) begin
                                n_tally = r_tally + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                if (r_going) begin
                    w_raddr = r_src;
                    n_pend  = 1'b1;
                    n_psrc  = r_src;
                    if (r_src == r_end) begin
                        n_going = 1'b0;
                    end else if (r_up) begin
                        n_src = r_src + AW'(1);
                    end else begin
                        n_src = r_src - AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_going && !r_pend) begin
                    if (r_op.opc == OP_INS) begin
                        n_state = S_FIN;
                    end else begin
                        if (r_op.opc == OP_DEL) begin
                            n_count = r_count - CW'(1);
                        end
                        n_res.status         = ST_OK;
                        n_res.removed_value  = VAL_W'(r_removed);
                        n_res.found_position = OUT_W'(r_found);
                        n_res.tally          = OUT_W'(r_tally);
                        n_ovalid             = 1'b1;
                        n_state              = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                w_we     = 1'b1;
                w_waddr  = r_at;
                w_wdata  = w_key;
                n_count  = r_count + CW'(1);
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            S_RA: begin
                w_raddr = r_lo;
                n_state = S_RB;
            end
            S_RB: begin
                w_raddr = r_hi;
                n_tmp   = r_rd;
                n_state = S_RC;
            end
            S_RC: begin
                w_we    = 1'b1;
                w_waddr = r_lo;
                n_state = S_RD;
            end
            S_RD: begin
                w_we    = 1'b1;
                w_waddr = r_hi;
                w_wdata = r_tmp;
                n_lo    = r_lo + AW'(1);
                n_hi    = r_hi - AW'(1);
                if ((AW + 1)'(r_lo) + (AW + 1)'(2) < (AW + 1)'(r_hi)) begin
                    w_raddr = r_lo + AW'(1);
                    n_state = S_RB;
                end else begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_end     <= n_end;
        r_psrc    <= n_psrc;
        r_at      <= n_at;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_up      <= n_up;
        r_tmp     <= n_tmp;
        r_removed <= n_removed;
        r_found   <= n_found;
        r_tally   <= n_tally;
        r_op      <= n_op;
        r_res     <= n_res;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_going  <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_going  <= n_going;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// ----- rtl/positional_list_engine_top.sv -----
`timescale 1ns / 1ps
// Positional list engine: front stage, operation queue and back stage.
// Count, clear, bad and full requests are answered from idle without a list walk.
// Deletes and searches walk the list at one memory access per cycle; inserts shift
// the entries after the insertion point, then write the value; reverse swaps pairs.
// Throughput: the back stage runs one request at a time. Reset clears the entry count
// and handshake state; list memory is not cleared. Depends on ple_pkg and submodules.
module positional_list_engine_top #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  ple_pkg::t_req i_req,
    output logic          o_req_stall,
    output logic          o_res_valid,
    output ple_pkg::t_res o_res,
    input  logic          i_res_stall
);
    import ple_pkg::*;

    logic w_f_valid;
    t_op  w_f_op;
    logic w_f_stall;
    logic w_q_valid;
    t_op  w_q_op;
    logic w_q_stall;

    ple_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_op_valid  (w_f_valid),
        .o_op        (w_f_op),
        .i_op_stall  (w_f_stall)
    );

    ple_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_op    (w_f_op),
        .o_stall (w_f_stall),
        .o_valid (w_q_valid),
        .o_op    (w_q_op),
        .i_stall (w_q_stall)
    );

    ple_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_q_valid),
        .i_op        (w_q_op),
        .o_op_stall  (w_q_stall),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

// ----- tb/positional_list_engine_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the positional list engine: directed and random list requests,
// each result checked against an in-bench list predictor. Depends on ple_pkg.
module positional_list_engine_top_tb;
    import ple_pkg::*;

    localparam int CAP = 64;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req = '0;
    logic o_req_stall;
    logic o_res_valid;
    t_res o_res;
    logic i_res_stall = 1'b0;

    logic signed [VAL_W-1:0] list_mirror [CAP];
    int unsigned mirror_count = 0;
    t_res expected_results [$];
    int unsigned mismatch_count = 0;

    positional_list_engine_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic t_res predict_list(t_req rq);
        t_res rs;
        int unsigned at;
        logic signed [VAL_W-1:0] t;
        rs = '0;
        case (rq.kind)
            K_INS_FIRST, K_INS_LAST, K_INS_AT: begin
                if (rq.kind == K_INS_AT &&
                    (rq.position == 0 || rq.position > mirror_count + 1)) begin
                    rs.status = ST_BADPOS;
                end else if (mirror_count >= CAP) begin
                    rs.status = ST_FULL;
                end else begin
                    at = (rq.kind == K_INS_FIRST) ? 0 :
                         (rq.kind == K_INS_LAST) ? mirror_count : rq.position - 1;
                    for (int i = mirror_count; i > at; i--) list_mirror[i] = list_mirror[i-1];
                    list_mirror[at] = rq.value;
                    mirror_count++;
                end
            end
            K_DEL_FIRST, K_DEL_LAST, K_DEL_AT: begin
                if (rq.kind != K_DEL_AT && mirror_count == 0) begin
                    rs.status = ST_EMPTY;
                end else if (rq.kind == K_DEL_AT &&
                             (rq.position == 0 || rq.position > mirror_count)) begin
                    rs.status = ST_BADPOS;
                end else begin
                    at = (rq.kind == K_DEL_FIRST) ? 0 :
                         (rq.kind == K_DEL_LAST) ? mirror_count - 1 : rq.position - 1;
                    rs.removed_value = list_mirror[at];
                    for (int i = at; i + 1 < mirror_count; i++) list_mirror[i] = list_mirror[i+1];
                    mirror_count--;
                end
            end
            K_FIND_FIRST: begin
                for (int i = mirror_count - 1; i >= 0; i--)
                    if (list_mirror[i] == rq.value) rs.found_position = OUT_W'(i + 1);
            end
            K_FIND_LAST: begin
                for (int i = 0; i < mirror_count; i++)
                    if (list_mirror[i] == rq.value) rs.found_position = OUT_W'(i + 1);
            end
            K_COUNT_KEY: begin
                for (int i = 0; i < mirror_count; i++)
                    if (list_mirror[i] == rq.value) rs.tally++;
            end
            K_COUNT: rs.tally = OUT_W'(mirror_count);
            K_REVERSE: begin
                for (int i = 0; i < mirror_count / 2; i++) begin
                    t = list_mirror[i];
                    list_mirror[i] = list_mirror[mirror_count-1-i];
                    list_mirror[mirror_count-1-i] = t;
                end
            end
            K_CLEAR: mirror_count = 0;
            default: ;
        endcase
        return rs;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_request(logic [KIND_W-1:0] kind, int unsigned pos,
                                logic signed [VAL_W-1:0] value);
        t_req rq;
        int unsigned g;
        rq.kind = kind;
        rq.position = pos[POS_W-1:0];
        rq.value = value;
        g = gap_len();
        if (g != 0) begin
            i_req_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= rq;
        expected_results.push_back(predict_list(rq));
        do @(posedge i_clk); while (o_req_stall);
    endtask

    // check each result as it is accepted
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_res, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
                if (o_res.removed_value !== want.removed_value)
                    report_mismatch("removed_value", o_res.removed_value, want.removed_value);
                if (o_res.found_position !== want.found_position)
                    report_mismatch("found_position", o_res.found_position,
                                    want.found_position);
                if (o_res.tally !== want.tally)
                    report_mismatch("tally", o_res.tally, want.tally);
            end
        end
    end

    // stall the result side at random, with calm stretches
    initial begin
        int unsigned g;
        forever begin
            g = gap_len();
            @(posedge i_clk);
            if (g != 0) begin
                i_res_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
                i_res_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 1) ? 0 : $urandom_range(20, 200)) @(posedge i_clk);
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return VAL_W'($urandom_range(0, 7));
            1: return -$signed(VAL_W'($urandom_range(1, 4)));
            2: return 32'sh8000_0000 + VAL_W'($urandom_range(0, 1));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_cases();
        send_request(K_DEL_FIRST, 0, 0);
        send_request(K_DEL_LAST, 0, 0);
        send_request(K_DEL_AT, 1, 0);
        send_request(K_FIND_FIRST, 0, 0);
        send_request(K_FIND_LAST, 0, 0);
        send_request(K_COUNT_KEY, 0, 0);
        send_request(K_REVERSE, 0, 0);
        send_request(K_CLEAR, 0, 0);
        send_request(K_INS_AT, 0, 5);
        send_request(K_INS_AT, 2, 5);
    endtask

    task automatic test_directed_ops();
        send_request(K_INS_AT, 1, 32'sh7fff_ffff);
        send_request(K_INS_FIRST, 0, 32'sh8000_0000);
        send_request(K_INS_LAST, 0, -1);
        send_request(K_INS_AT, 4, 0);
        send_request(K_FIND_FIRST, 0, -1);
        send_request(K_FIND_LAST, 0, 32'sh8000_0000);
        send_request(K_COUNT_KEY, 0, 0);
        send_request(K_COUNT, 0, 0);
        send_request(K_REVERSE, 0, 0);
        send_request(K_DEL_AT, 5, 0);
        send_request(K_DEL_AT, 127, 0);
        send_request(K_DEL_AT, 2, 0);
        send_request(K_DEL_FIRST, 0, 0);
        send_request(K_DEL_LAST, 0, 0);
        send_request(4'd15, 127, -1);
        send_request(K_CLEAR, 0, 0);
    endtask

    task automatic test_full_list();
        for (int i = 0; i < CAP; i++) send_request(K_INS_LAST, 0, VAL_W'(i % 5));
        send_request(K_INS_FIRST, 0, 1);
        send_request(K_INS_AT, 65, 1);
        send_request(K_INS_AT, 66, 1);
        send_request(K_COUNT, 0, 0);
        send_request(K_COUNT_KEY, 0, 0);
        send_request(K_FIND_LAST, 0, 4);
        send_request(K_REVERSE, 0, 0);
        send_request(K_DEL_AT, 64, 0);
        send_request(K_CLEAR, 0, 0);
    endtask

    task automatic test_random_requests(int unsigned n);
        int unsigned r;
        int unsigned p;
        logic [KIND_W-1:0] k;
        for (int unsigned j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (mirror_count < 20)
                k = KIND_W'((r < 45) ? $urandom_range(0, 2) : $urandom_range(0, 11));
            else
                k = KIND_W'((r < 30) ? $urandom_range(3, 5) : $urandom_range(0, 11));
            if ($urandom_range(0, 199) == 0) k = KIND_W'($urandom_range(12, 15));
            if ($urandom_range(0, 59) == 0) k = K_CLEAR;
            p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) :
                $urandom_range(0, mirror_count + 1);
            send_request(k, p, pick_value());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_cases();
        test_directed_ops();
        test_full_list();
        test_random_requests(750);
        i_req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
